@@ rtl/core/lerc_pkg.sv @@
// ----------------------------------------------------------------------------
// lerc_pkg
// Shared types, codes and helpers for the little-endian RAM with
// compare-and-exchange.
// ----------------------------------------------------------------------------
package lerc_pkg;

  localparam int unsigned MEM_BYTES_DEF = 65536;

  localparam logic [1:0] ACT_READ  = 2'd0;
  localparam logic [1:0] ACT_WRITE = 2'd1;
  localparam logic [1:0] ACT_CAS   = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_WIDTH = 2'd1;
  localparam logic [1:0] ST_OOB       = 2'd2;

  typedef struct packed {
    logic [1:0]  action;
    logic [63:0] byte_offset;
    logic [3:0]  access_bytes;
    logic [63:0] store_value;
    logic [63:0] compare_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] read_data;
    logic        swapped;
  } out_item_t;

  // Per-access control handed to the merge datapath
  typedef struct packed {
    logic [2:0]  shift;
    logic        word_odd;
    logic [3:0]  len;
  } op_ctl_t;

  function automatic logic [63:0] width_mask(input logic [3:0] len);
    logic [63:0] m;
    case (len)
      4'd1:    m = 64'h0000_0000_0000_00FF;
      4'd2:    m = 64'h0000_0000_0000_FFFF;
      4'd4:    m = 64'h0000_0000_FFFF_FFFF;
      default: m = 64'hFFFF_FFFF_FFFF_FFFF;
    endcase
    return m;
  endfunction

endpackage

@@ rtl/core/little_endian_ram_with_cas_unit.sv @@
// ----------------------------------------------------------------------------
// little_endian_ram_with_cas_unit
// Byte-addressed little-endian RAM with read, write and compare-exchange.
//
// Input channel (in_valid/in_stall/in_data) carries one access per item;
// the result channel (out_valid/out_stall/out_data) returns one item each.
// Storage is two 64-bit banks of even and odd words, so any unaligned
// access of up to 8 bytes reads one word from each bank in the same cycle.
// An item is accepted and its words read in the same cycle; in S_EXEC it
// is merged, written back and loaded into the output register. in_stall
// stays high in S_EXEC, so a new item is taken only after the previous
// one has left it. After reset a clearing pass zeroes all WORDS/2 + 1 rows
// of the banks (WORDS is MEM_BYTES rounded up to whole words), one row per
// cycle; in_stall is high meanwhile. If out_stall holds a result, the next
// finished item waits in the merge cycle until the output register is free.
// ----------------------------------------------------------------------------
module little_endian_ram_with_cas_unit import lerc_pkg::*; #(
  parameter int unsigned MEM_BYTES = MEM_BYTES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int unsigned WORDS = (MEM_BYTES + 7) / 8;
  localparam int unsigned ROWS  = WORDS / 2 + 1;
  localparam int unsigned RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam logic [RW-1:0] LAST_ROW = RW'(ROWS - 1);

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_EXEC} state_t;

  state_t        state_r;
  logic [RW-1:0] clr_cnt_r;
  in_item_t      op_r;
  logic [1:0]    status_r;
  logic [RW-1:0] even_row_r;
  logic [RW-1:0] odd_row_r;
  out_item_t     out_r;
  logic          out_valid_r;

  logic          accept;
  logic          load_out;
  logic [63:0]   word_idx;
  logic [63:0]   even_word;
  logic [RW-1:0] even_row;
  logic [RW-1:0] odd_row;
  logic          len_ok;
  logic [64:0]   end_pos;
  logic [1:0]    status_nxt;
  op_ctl_t       ctl;
  logic [63:0]   rd_even;
  logic [63:0]   rd_odd;
  logic [63:0]   old_value;
  logic          match;
  logic [63:0]   new_even;
  logic [63:0]   new_odd;
  logic          do_write;
  logic          bank_we;
  logic [RW-1:0] even_waddr;
  logic [RW-1:0] odd_waddr;
  logic [63:0]   even_wdata;
  logic [63:0]   odd_wdata;
  out_item_t     out_nxt;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign load_out = (state_r == S_EXEC) && (!out_valid_r || !out_stall);

  // bank rows for the first word and the word after it
  always_comb begin
    word_idx  = in_data.byte_offset >> 3;
    even_word = (word_idx + 64'd1) >> 1;
    even_row  = even_word[RW-1:0];
    odd_row   = word_idx[RW:1];
  end

  always_comb begin
    len_ok  = (in_data.access_bytes == 4'd1) || (in_data.access_bytes == 4'd2) ||
              (in_data.access_bytes == 4'd4) || (in_data.access_bytes == 4'd8);
    end_pos = {1'b0, in_data.byte_offset} + {61'd0, in_data.access_bytes};
    if (!len_ok) begin
      status_nxt = ST_BAD_WIDTH;
    end else if (end_pos > 65'(MEM_BYTES)) begin
      status_nxt = ST_OOB;
    end else begin
      status_nxt = ST_OK;
    end
  end

  assign ctl.shift    = op_r.byte_offset[2:0];
  assign ctl.word_odd = op_r.byte_offset[3];
  assign ctl.len      = op_r.access_bytes;

  lerc_merge u_merge (
    .ctl           (ctl),
    .rd_even       (rd_even),
    .rd_odd        (rd_odd),
    .store_value   (op_r.store_value),
    .compare_value (op_r.compare_value),
    .old_value     (old_value),
    .match         (match),
    .new_even      (new_even),
    .new_odd       (new_odd)
  );

  always_comb begin
    do_write = load_out && (status_r == ST_OK) &&
               ((op_r.action == ACT_WRITE) || ((op_r.action == ACT_CAS) && match));
    if (state_r == S_CLEAR) begin
      bank_we    = 1'b1;
      even_waddr = clr_cnt_r;
      odd_waddr  = clr_cnt_r;
      even_wdata = 64'd0;
      odd_wdata  = 64'd0;
    end else begin
      bank_we    = do_write;
      even_waddr = even_row_r;
      odd_waddr  = odd_row_r;
      even_wdata = new_even;
      odd_wdata  = new_odd;
    end
  end

  lerc_bank #(.ROWS(ROWS), .RW(RW)) u_even (
    .clk   (clk),
    .we    (bank_we),
    .waddr (even_waddr),
    .wdata (even_wdata),
    .re    (accept),
    .raddr (even_row),
    .rdata (rd_even)
  );

  lerc_bank #(.ROWS(ROWS), .RW(RW)) u_odd (
    .clk   (clk),
    .we    (bank_we),
    .waddr (odd_waddr),
    .wdata (odd_wdata),
    .re    (accept),
    .raddr (odd_row),
    .rdata (rd_odd)
  );

  always_comb begin
    out_nxt.status    = status_r;
    out_nxt.read_data = 64'd0;
    out_nxt.swapped   = 1'b0;
    if (status_r == ST_OK) begin
      case (op_r.action)
        ACT_READ: out_nxt.read_data = old_value;
        ACT_CAS: begin
          out_nxt.read_data = old_value;
          out_nxt.swapped   = match;
        end
        default: out_nxt.read_data = 64'd0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        S_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + 1'b1;
          if (clr_cnt_r == LAST_ROW) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          // hold while the previous result is still stalled
          if (load_out) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_CLEAR;
      endcase
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r       <= in_data;
      status_r   <= status_nxt;
      even_row_r <= even_row;
      odd_row_r  <= odd_row;
    end
    if (load_out) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

@@ rtl/core/lerc_bank.sv @@
// ----------------------------------------------------------------------------
// lerc_bank
// One 64-bit wide synchronous RAM bank, one write and one read port,
// registered read data.
// ----------------------------------------------------------------------------
module lerc_bank #(
  parameter int unsigned ROWS = 2,
  parameter int unsigned RW   = 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [RW-1:0] waddr,
  input  logic [63:0]   wdata,
  input  logic          re,
  input  logic [RW-1:0] raddr,
  output logic [63:0]   rdata
);

  logic [63:0] mem [ROWS];
  logic [63:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/core/lerc_merge.sv @@
// ----------------------------------------------------------------------------
// lerc_merge
// Assembles the two-word window around an access, extracts the old value,
// compares it and builds the written-back words.
// ----------------------------------------------------------------------------
module lerc_merge import lerc_pkg::*; (
  input  op_ctl_t     ctl,
  input  logic [63:0] rd_even,
  input  logic [63:0] rd_odd,
  input  logic [63:0] store_value,
  input  logic [63:0] compare_value,
  output logic [63:0] old_value,
  output logic        match,
  output logic [63:0] new_even,
  output logic [63:0] new_odd
);

  logic [127:0] window;
  logic [127:0] shifted;
  logic [127:0] mask_w;
  logic [127:0] data_w;
  logic [127:0] new_window;
  logic [63:0]  mask;
  logic [6:0]   sh;

  always_comb begin
    mask       = width_mask(ctl.len);
    sh         = {ctl.shift, 3'b000};
    // low half of the window is the word holding the first byte
    window     = ctl.word_odd ? {rd_even, rd_odd} : {rd_odd, rd_even};
    shifted    = window >> sh;
    old_value  = shifted[63:0] & mask;
    match      = (old_value == (compare_value & mask));
    mask_w     = {64'd0, mask} << sh;
    data_w     = {64'd0, store_value & mask} << sh;
    new_window = (window & ~mask_w) | data_w;
    new_even   = ctl.word_odd ? new_window[127:64] : new_window[63:0];
    new_odd    = ctl.word_odd ? new_window[63:0]   : new_window[127:64];
  end

endmodule

@@ bench/little_endian_ram_with_cas_unit_tb.sv @@
// ----------------------------------------------------------------------------
// little_endian_ram_with_cas_unit_tb
// Drives reads, writes and compare-exchanges into the byte RAM, with random
// idle gaps on the input side and random stalls on the result side. A byte
// image of the memory predicts every result. The results are checked in
// order, field by field.
// ----------------------------------------------------------------------------
module little_endian_ram_with_cas_unit_tb;
  import lerc_pkg::*;

  localparam int unsigned RAM_SIZE = MEM_BYTES_DEF;
  localparam logic [1:0] ACT_NONE = 2'd3;
  localparam int unsigned RANDOM_ITEMS = 680;

  class cas_scoreboard;
    bit [7:0]  ram_image [RAM_SIZE];
    out_item_t pending[$];
    int        errors;

    function new();
      errors = 0;
    endfunction

    function logic [63:0] lane_mask(logic [3:0] len);
      if (len >= 4'd8) return '1;
      return (64'd1 << (len * 8)) - 64'd1;
    endfunction

    function bit width_ok(logic [3:0] len);
      return len == 4'd1 || len == 4'd2 || len == 4'd4 || len == 4'd8;
    endfunction

    function bit in_range(logic [63:0] off, logic [3:0] len);
      logic [63:0] size;
      size = 64'(RAM_SIZE);
      return !(off > size || {60'd0, len} > size - off);
    endfunction

    // Value stored at the given bytes, lowest offset in the low byte
    function logic [63:0] peek(logic [63:0] off, logic [3:0] len);
      logic [63:0] v;
      v = '0;
      if (!width_ok(len) || !in_range(off, len)) return v;
      for (int i = 0; i < len; i++) v[i*8 +: 8] = ram_image[off[31:0] + i];
      return v;
    endfunction

    function void poke(logic [63:0] off, logic [3:0] len, logic [63:0] v);
      for (int i = 0; i < len; i++) ram_image[off[31:0] + i] = v[i*8 +: 8];
    endfunction

    function void note_input(in_item_t it);
      out_item_t r;
      logic [63:0] mask;
      r = '0;
      r.status = ST_OK;
      mask = lane_mask(it.access_bytes);
      if (!width_ok(it.access_bytes)) begin
        r.status = ST_BAD_WIDTH;
      end else if (!in_range(it.byte_offset, it.access_bytes)) begin
        r.status = ST_OOB;
      end else begin
        case (it.action)
          ACT_READ: begin
            r.read_data = peek(it.byte_offset, it.access_bytes);
          end
          ACT_WRITE: begin
            poke(it.byte_offset, it.access_bytes, it.store_value);
          end
          ACT_CAS: begin
            r.read_data = peek(it.byte_offset, it.access_bytes);
            if (r.read_data == (it.compare_value & mask)) begin
              poke(it.byte_offset, it.access_bytes, it.store_value & mask);
              r.swapped = 1'b1;
            end
          end
          default: ;
        endcase
      end
      pending.push_back(r);
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.status !== want.status) begin
        $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
        errors++;
      end
      if (got.read_data !== want.read_data) begin
        $display("%0t: read_data expected %h actual %h", $time, want.read_data,
                 got.read_data);
        errors++;
      end
      if (got.swapped !== want.swapped) begin
        $display("%0t: swapped expected %0b actual %0b", $time, want.swapped,
                 got.swapped);
        errors++;
      end
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;
  bit        calm = 1'b0;

  cas_scoreboard sb = new();

  little_endian_ram_with_cas_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("TB_ERROR");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  // Result side: stall for a random count, then take one item
  initial begin
    int n;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      n = calm ? 0 : $urandom_range(0, 15);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  function automatic in_item_t access(logic [1:0] act, logic [63:0] off, logic [3:0] len,
                                      logic [63:0] val, logic [63:0] cmp);
    in_item_t it;
    it.action        = act;
    it.byte_offset   = off;
    it.access_bytes  = len;
    it.store_value   = val;
    it.compare_value = cmp;
    return it;
  endfunction

  task automatic send(in_item_t it);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    sb.note_input(it);
  endtask

  function automatic in_item_t random_access();
    in_item_t    it;
    int          pick;
    logic [63:0] mask;
    pick = $urandom_range(0, 99);
    if (pick < 30)      it.action = ACT_READ;
    else if (pick < 60) it.action = ACT_WRITE;
    else if (pick < 95) it.action = ACT_CAS;
    else                it.action = ACT_NONE;

    pick = $urandom_range(0, 99);
    if (pick < 88) begin
      case ($urandom_range(0, 3))
        0: it.access_bytes = 4'd1;
        1: it.access_bytes = 4'd2;
        2: it.access_bytes = 4'd4;
        default: it.access_bytes = 4'd8;
      endcase
    end else begin
      it.access_bytes = 4'($urandom_range(0, 15));
    end

    // Keep most accesses in a small window so that bytes are revisited
    pick = $urandom_range(0, 99);
    if (pick < 60)      it.byte_offset = 64'($urandom_range(0, 95));
    else if (pick < 75) it.byte_offset = 64'(RAM_SIZE - $urandom_range(1, 16));
    else if (pick < 90) it.byte_offset = 64'($urandom_range(0, RAM_SIZE - 1));
    else                it.byte_offset = {$urandom, $urandom};

    it.store_value = ($urandom_range(0, 3) == 0) ? 64'($urandom_range(0, 255))
                                                 : {$urandom, $urandom};
    mask = sb.lane_mask(it.access_bytes);
    // Half the exchanges compare against the live value, with junk above the width
    if ($urandom_range(0, 1) == 1)
      it.compare_value = sb.peek(it.byte_offset, it.access_bytes) |
                         ({$urandom, $urandom} & ~mask);
    else
      it.compare_value = {$urandom, $urandom};
    return it;
  endfunction

  localparam logic [63:0] TOP = 64'(RAM_SIZE);

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed accesses
    send(access(ACT_READ,  64'd0, 4'd8, '0, '0));
    send(access(ACT_WRITE, 64'd5, 4'd8, 64'h8877_6655_4433_2211, '0));
    send(access(ACT_READ,  64'd5, 4'd1, '0, '0));
    send(access(ACT_READ,  64'd6, 4'd2, '0, '0));
    send(access(ACT_READ,  64'd7, 4'd4, '0, '0));
    send(access(ACT_READ,  64'd4, 4'd8, '0, '0));
    send(access(ACT_WRITE, 64'd3, 4'd4, '1, '0));
    send(access(ACT_READ,  64'd0, 4'd8, '0, '0));
    send(access(ACT_WRITE, TOP - 8, 4'd8, 64'hDEAD_BEEF_CAFE_F00D, '0));
    send(access(ACT_READ,  TOP - 1, 4'd1, '0, '0));
    send(access(ACT_READ,  TOP - 8, 4'd8, '0, '0));
    // Out of bounds: one byte past the end, at the end, and wrapping offsets
    send(access(ACT_WRITE, TOP - 1, 4'd2, '1, '0));
    send(access(ACT_READ,  TOP, 4'd1, '0, '0));
    send(access(ACT_WRITE, '1, 4'd1, '1, '0));
    send(access(ACT_CAS,   64'hFFFF_FFFF_FFFF_FFF9, 4'd8, '1, '0));
    // Bad width wins over out of bounds
    send(access(ACT_READ,  '1, 4'd0, '0, '0));
    send(access(ACT_WRITE, 64'd16, 4'd3, '1, '0));
    send(access(ACT_CAS,   64'd16, 4'd15, '1, '0));
    // Exchange: match only after masking, then a mismatch, then a full-width match and a read back
    send(access(ACT_CAS,   64'd40, 4'd2, 64'hFFFF_FFFF_FFFF_A55A, 64'hFFFF_0000));
    send(access(ACT_CAS,   64'd40, 4'd2, 64'h1234, 64'h0));
    send(access(ACT_CAS,   64'd40, 4'd8, '1, 64'hA55A));
    send(access(ACT_READ,  64'd40, 4'd8, '0, '0));
    // Unused action, in range and out of range
    send(access(ACT_NONE,  64'd5, 4'd8, '1, '1));
    send(access(ACT_NONE,  TOP, 4'd4, '1, '1));

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      calm = ((i / 60) % 4) == 1;
      send(random_access());
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/lerc_pkg.sv
rtl/core/lerc_bank.sv
rtl/core/lerc_merge.sv
rtl/core/little_endian_ram_with_cas_unit.sv
bench/little_endian_ram_with_cas_unit_tb.sv
